@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// Clocked concurrent assertions with a synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BEE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BEE_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hdl/bee_pkg.sv @@
// ----------------------------------------------------------------------------
// bee_pkg
// Types and fixed constants of the byte entropy estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package bee_pkg;

   localparam int NUM_BINS = 256;
   localparam int BIN_BITS = 8;
   localparam int ENT_BITS = 20;
   localparam int RGN_BITS = 32;

   typedef struct packed {
      logic [BIN_BITS-1:0] data_byte;
      logic                has_byte;
      logic                last_of_region;
   } req_type;

   typedef struct packed {
      logic [ENT_BITS-1:0] entropy_value;
      logic [RGN_BITS-1:0] region_bytes;
      logic                count_overflow;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/bee_ram.sv @@
// ----------------------------------------------------------------------------
// bee_ram
// Generic single-write, single-read RAM, registered read, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module bee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/bee_log2.sv @@
// ----------------------------------------------------------------------------
// bee_log2
// Iterative fixed-point log2: leading-one detect, then one squaring per
// fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bee_log2 #(
   parameter int COUNT_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       start,
   input  wire logic [COUNT_BITS-1:0]                      x,
   output logic                                            done,
   output logic [$clog2(COUNT_BITS)+FRAC_BITS-1:0]         value
);

   localparam int KW = $clog2(COUNT_BITS);
   localparam int W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;
   localparam int SW = $clog2(W);
   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [KW-1:0]        k;
   logic [W-1:0]         x_w;
   logic [SW-1:0]        sh;
   logic [W-1:0]         norm;
   logic [63:0]          sq;
   logic                 bit_now;
   logic [31:0]          m_next;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [31:0]          m_ff, m_in;
   logic [KW-1:0]        k_ff, k_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;

   // leading one
   always_comb begin
      k = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (x[i]) begin
            k = KW'(i);
         end
      end
   end

   assign x_w  = W'(x);
   assign sh   = SW'(W - 1) - SW'(k);
   assign norm = x_w << sh;

   assign sq      = 64'(m_ff) * 64'(m_ff);
   assign bit_now = sq[63];
   assign m_next  = bit_now ? sq[63:32] : sq[62:31];

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      k_in    = k_ff;
      frac_in = frac_ff;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         m_in    = norm[W-1 -: 32];
         k_in    = k;
         frac_in = '0;
      end else if (run_ff) begin
         m_in    = m_next;
         frac_in = {frac_ff[FRAC_BITS-2:0], bit_now};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(FRAC_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff    <= m_in;
      k_ff    <= k_in;
      frac_ff <= frac_in;
   end

   assign done  = done_ff;
   assign value = {k_ff, frac_ff};

endmodule

`default_nettype wire

@@ hdl/byte_entropy_estimator_top.sv @@
// ----------------------------------------------------------------------------
// byte_entropy_estimator_top
// Byte histogram in a 256-entry RAM and Shannon entropy in bits per byte,
// emitted once per region as unsigned fixed point.
// ----------------------------------------------------------------------------
//  channel  | ports                      | handshake
//  ---------+----------------------------+----------------------------------
//  request  | start, busy, req_data      | beat taken when start && !busy
//  response | rsp_strobe, rsp_data       | one-cycle strobe, cannot be held
//
//  Bytes are taken one per cycle while busy is low; each beat is a
//  read-modify-write of its bin, with the previous write forwarded when the
//  same bin repeats. A last beat raises busy for the end pass: log2(N), then
//  per bin a read, and for a nonempty bin the squaring loop of the log2
//  unit and a shift-add multiply, then a restoring divide of ACC_BITS
//  quotient bits and the output. The pass also zeroes every bin. Reset is
//  synchronous and does not reach the RAM: after reset the block runs one
//  clearing sweep over all 256 bins with busy high, and every later region
//  finds the bins zeroed by the previous end pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_entropy_estimator_top #(
   parameter int COUNT_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bee_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output bee_pkg::rsp_type      rsp_data
);

   import bee_pkg::*;

   localparam int KW       = $clog2(COUNT_BITS);
   localparam int LOG_BITS = KW + FRAC_BITS;
   localparam int ACC_BITS = COUNT_BITS + LOG_BITS;
   localparam int CNT_W    = $clog2(ACC_BITS + 1);
   localparam int CMP_BITS = ACC_BITS + ENT_BITS;
   localparam int RB       = COUNT_BITS + RGN_BITS;

   localparam logic [3:0] S_RUN  = 4'd0;
   localparam logic [3:0] S_NCHK = 4'd1;
   localparam logic [3:0] S_LOGN = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_RDW  = 4'd4;
   localparam logic [3:0] S_LOGC = 4'd5;
   localparam logic [3:0] S_MUL  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;
   localparam logic [3:0] S_CLR  = 4'd9;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CMP_BITS-1:0]   ENT_LIM   = CMP_BITS'(8) << FRAC_BITS;
   localparam logic [CMP_BITS-1:0]   ENT_MAXV  = CMP_BITS'({ENT_BITS{1'b1}});

   // control state
   logic [3:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  ovf_ff, ovf_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  lw_valid_ff, lw_valid_in;
   logic [BIN_BITS-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;

   // datapath
   logic [BIN_BITS-1:0]   s1_addr_ff, s1_addr_in;
   logic [BIN_BITS-1:0]   lw_addr_ff, lw_addr_in;
   logic [COUNT_BITS-1:0] lw_data_ff, lw_data_in;
   logic [LOG_BITS-1:0]   ln_ff, ln_in;
   logic [ACC_BITS-1:0]   mul_m_ff, mul_m_in;
   logic [LOG_BITS-1:0]   mul_d_ff, mul_d_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // RAM ports
   logic                  wr_en;
   logic [BIN_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [BIN_BITS-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] rd_data;

   // log2 unit
   logic                  log_start;
   logic [COUNT_BITS-1:0] log_x;
   logic                  log_done;
   logic [LOG_BITS-1:0]   log_value;

   logic                  accept;
   logic                  count_ok;
   logic [COUNT_BITS-1:0] fwd;
   logic [COUNT_BITS:0]   rem_sh;
   logic                  q_bit;
   logic [CMP_BITS-1:0]   q_ext;
   logic [CMP_BITS-1:0]   q_clamp;
   logic [RB-1:0]         t_ext;

   assign busy     = (state_ff != S_RUN);
   assign accept   = start && !busy;
   assign count_ok = req_data.has_byte && (total_ff != COUNT_MAX);

   // forward the write that landed while this beat's read was in flight
   assign fwd = (lw_valid_ff && (lw_addr_ff == s1_addr_ff)) ? lw_data_ff : rd_data;

   assign rd_addr = (state_ff == S_RUN) ? req_data.data_byte : idx_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s1_addr_ff;
      wr_data = fwd + 1'b1;
      if (s1_valid_ff) begin
         wr_en = 1'b1;
      end else if ((state_ff == S_RDW) || (state_ff == S_CLR)) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         wr_data = '0;
      end
   end

   assign log_x = (state_ff == S_NCHK) ? total_ff : rd_data;

   // restoring divide step
   assign rem_sh = {rem_ff, acc_ff[ACC_BITS-1]};
   assign q_bit  = (rem_sh >= {1'b0, total_ff});

   // entropy clamp and byte-count saturation
   assign q_ext   = CMP_BITS'(acc_ff);
   always_comb begin
      q_clamp = q_ext;
      if (q_clamp > ENT_LIM) begin
         q_clamp = ENT_LIM;
      end
      if (q_clamp > ENT_MAXV) begin
         q_clamp = ENT_MAXV;
      end
   end
   assign t_ext = RB'(total_ff);

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      s1_valid_in  = 1'b0;
      s1_addr_in   = req_data.data_byte;
      lw_valid_in  = s1_valid_ff;
      lw_addr_in   = s1_addr_ff;
      lw_data_in   = fwd + 1'b1;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      acc_in       = acc_ff;
      ln_in        = ln_ff;
      mul_m_in     = mul_m_ff;
      mul_d_in     = mul_d_ff;
      rem_in       = rem_ff;
      log_start    = 1'b0;

      unique case (state_ff)
         S_CLR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == BIN_BITS'(NUM_BINS - 1)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (accept) begin
               if (req_data.has_byte) begin
                  if (count_ok) begin
                     total_in    = total_ff + 1'b1;
                     s1_valid_in = 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_data.last_of_region) begin
                  state_in = S_NCHK;
               end
            end
         end
         S_NCHK: begin
            acc_in = '0;
            if (total_ff == '0) begin
               state_in = S_OUT;
            end else begin
               log_start = 1'b1;
               state_in  = S_LOGN;
            end
         end
         S_LOGN: begin
            if (log_done) begin
               ln_in    = log_value;
               idx_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            mul_m_in = ACC_BITS'(rd_data);
            if (rd_data == '0) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == BIN_BITS'(NUM_BINS - 1)) begin
                  cnt_in   = '0;
                  rem_in   = '0;
                  state_in = S_DIV;
               end else begin
                  state_in = S_RD;
               end
            end else begin
               log_start = 1'b1;
               state_in  = S_LOGC;
            end
         end
         S_LOGC: begin
            if (log_done) begin
               mul_d_in = (log_value < ln_ff) ? (ln_ff - log_value) : '0;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_d_ff[0]) begin
               acc_in = acc_ff + mul_m_ff;
            end
            mul_m_in = mul_m_ff << 1;
            mul_d_in = mul_d_ff >> 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(LOG_BITS - 1)) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == BIN_BITS'(NUM_BINS - 1)) begin
                  cnt_in   = '0;
                  rem_in   = '0;
                  state_in = S_DIV;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_DIV: begin
            rem_in = q_bit ? COUNT_BITS'(rem_sh - {1'b0, total_ff})
                           : COUNT_BITS'(rem_sh);
            acc_in = {acc_ff[ACC_BITS-2:0], q_bit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ACC_BITS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.entropy_value   = q_clamp[ENT_BITS-1:0];
            rsp_data_in.region_bytes    = (t_ext > RB'({RGN_BITS{1'b1}}))
                                          ? {RGN_BITS{1'b1}} : t_ext[RGN_BITS-1:0];
            rsp_data_in.count_overflow  = ovf_ff;
            total_in                    = '0;
            ovf_in                      = 1'b0;
            acc_in                      = '0;
            state_in                    = S_RUN;
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         s1_valid_ff  <= s1_valid_in;
         lw_valid_ff  <= lw_valid_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
      s1_addr_ff  <= s1_addr_in;
      lw_addr_ff  <= lw_addr_in;
      lw_data_ff  <= lw_data_in;
      ln_ff       <= ln_in;
      mul_m_ff    <= mul_m_in;
      mul_d_ff    <= mul_d_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   bee_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bee_log2 #(
      .COUNT_BITS (COUNT_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_log2 (
      .clock (clock),
      .reset (reset),
      .start (log_start),
      .x     (log_x),
      .done  (log_done),
      .value (log_value)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/bee_checker.sv @@
// ----------------------------------------------------------------------------
// bee_checker
// Port-level checks of the byte entropy estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bee_checker #(
   parameter int FRAC_BITS = 16
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire bee_pkg::req_type req_data,
   input wire logic             rsp_strobe,
   input wire bee_pkg::rsp_type rsp_data
);

   import bee_pkg::*;

   localparam longint ENT_LIM = ((64'd8 << FRAC_BITS) > ((64'd1 << ENT_BITS) - 1))
                                ? ((64'd1 << ENT_BITS) - 1) : (64'd8 << FRAC_BITS);

   `BEE_ASSERT(a_last_goes_busy, clock, reset, start && !busy && req_data.last_of_region |=> busy, "last beat did not start the end pass")
   `BEE_ASSERT_NEVER(a_strobe_back_to_back, clock, reset, rsp_strobe && $past(rsp_strobe), "two result strobes in a row")
   `BEE_ASSERT_NEVER(a_strobe_while_busy, clock, reset, rsp_strobe && busy, "result shown while busy")
   `BEE_ASSERT(a_entropy_range, clock, reset, rsp_strobe |-> (64'(rsp_data.entropy_value) <= ENT_LIM), "entropy above 8 bits per byte")
   `BEE_ASSERT(a_empty_zero, clock, reset, rsp_strobe && (rsp_data.region_bytes == '0) |-> (rsp_data.entropy_value == '0), "empty region gave nonzero entropy")

endmodule

bind byte_entropy_estimator_top bee_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_bee_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte entropy estimator testbench
// Sends byte regions through the command port and checks each entropy result
// against a cycle-free predictor of the histogram and fixed-point entropy.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import bee_pkg::*;

   localparam int          FRAC = 16;
   localparam longint      CNT_MAX = 64'hFFFF_FFFF;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   // directed row: beat, whether a typed result applies, typed result
   typedef struct packed {
      req_type q;
      logic    chk;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   byte_entropy_estimator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state: histogram, byte total, saturation flag
   longint unsigned hist[NUM_BINS];
   longint unsigned byte_total;
   bit              sat_seen;
   rsp_type         expected_rsp[$];
   int              fail_count = 0;
   int unsigned     cycle_count = 0;
   int              send_idle_pct = 0;

   // truncated fixed-point log2, leading one plus squaring loop
   function automatic longint unsigned log2_fx(longint unsigned x);
      int              k;
      longint unsigned m;
      longint unsigned frac;
      k = 0;
      frac = 0;
      if (x == 0) return 0;
      for (int i = 0; i < 64; i++)
         if (x[i]) k = i;
      m = (k > 31) ? (x >> (k - 31)) : (x << (31 - k));
      for (int i = 0; i < FRAC; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return (longint'(k) << FRAC) | frac;
   endfunction

   function automatic rsp_type region_entropy();
      rsp_type         r;
      logic [127:0]    acc;
      longint unsigned ln, lc, d, h;
      acc = '0;
      h = 0;
      if (byte_total != 0) begin
         ln = log2_fx(byte_total);
         for (int b = 0; b < NUM_BINS; b++) begin
            if (hist[b] != 0) begin
               lc = log2_fx(hist[b]);
               d = (lc < ln) ? (ln - lc) : 0;
               acc += 128'(hist[b]) * 128'(d[31:0]);
            end
         end
         acc = acc / 128'(byte_total);
         h = (acc > 128'(64'(8) << FRAC)) ? (64'(8) << FRAC) : acc[63:0];
         if (h > 64'hF_FFFF) h = 64'hF_FFFF;
      end
      r.entropy_value = h[ENT_BITS-1:0];
      r.region_bytes = (byte_total > CNT_MAX) ? 32'hFFFF_FFFF : byte_total[31:0];
      r.count_overflow = sat_seen;
      return r;
   endfunction

   function automatic void clear_histogram();
      foreach (hist[i]) hist[i] = 0;
      byte_total = 0;
      sat_seen = 0;
   endfunction

   // update model for one accepted beat; queue the result on a last beat
   function automatic void absorb_beat(req_type q);
      if (q.has_byte) begin
         if (byte_total >= CNT_MAX) sat_seen = 1;
         else begin
            byte_total++;
            if (hist[q.data_byte] < CNT_MAX) hist[q.data_byte]++;
         end
      end
      if (q.last_of_region) begin
         expected_rsp.push_back(region_entropy());
         clear_histogram();
      end
   endfunction

   // start stays high into the next beat; callers drop it before a pause
   task automatic send_beat(req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      absorb_beat(q);
   endtask

   task automatic send_region(int len, int pattern);
      req_type q;
      for (int i = 0; i < len; i++) begin
         q.has_byte = ($urandom_range(15) != 0) || (pattern == 2);
         case (pattern)
            0: q.data_byte = 8'($urandom);
            1: q.data_byte = 8'($urandom_range(3));
            default: q.data_byte = 8'(i);
         endcase
         q.last_of_region = (i == len - 1);
         send_beat(q);
      end
   endtask

   // response monitor: results cannot be held off, so check on every strobe
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            fail_count++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.entropy_value !== e.entropy_value) begin
               $error("entropy_value exp %h got %h", e.entropy_value, rsp_data.entropy_value);
               fail_count++;
            end
            if (rsp_data.region_bytes !== e.region_bytes) begin
               $error("region_bytes exp %h got %h", e.region_bytes, rsp_data.region_bytes);
               fail_count++;
            end
            if (rsp_data.count_overflow !== e.count_overflow) begin
               $error("count_overflow exp %b got %b", e.count_overflow,
                      rsp_data.count_overflow);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // directed table: {data_byte, has_byte, last_of_region}, typed flag, typed result
   dir_row_type directed_rows[] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{20'h00000, 32'd0, 1'b0}},  // empty right after reset
      '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{20'h00000, 32'd1, 1'b0}},  // single byte: zero
      '{'{8'hFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{20'h10000, 32'd2, 1'b0}},  // two bins, one bit
      '{'{8'hA5, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'hA5, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'hA5, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hA5, 1'b1, 1'b1}, 1'b1, '{20'h00000, 32'd3, 1'b0}},  // repeated bin, gap beat
      '{'{8'h55, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hAA, 1'b0, 1'b1}, 1'b1, '{20'h00000, 32'd0, 1'b0}},  // only gap beats
      '{'{8'h01, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h02, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h04, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h08, 1'b1, 1'b1}, 1'b1, '{20'h20000, 32'd4, 1'b0}},  // four bins, two bits
      '{'{8'h10, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h20, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h40, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h7F, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'hFE, 1'b1, 1'b1}, 1'b0, '0},                         // six bins
      '{'{8'h33, 1'b0, 1'b1}, 1'b1, '{20'h00000, 32'd0, 1'b0}}   // empty region again
   };

   initial begin
      int n_items;
      clear_histogram();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].q);
         if (directed_rows[i].chk) expected_rsp[$] = directed_rows[i].want;
      end
      // every bin once: full 8 bits
      send_region(256, 2);
      start <= 1'b0;

      // hold off until the block has drained
      while (expected_rsp.size() != 0) @(posedge clock);

      n_items = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 56 : 0;
         while (n_items < (phase + 1) * 140) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
            send_region(len, $urandom_range(1));
            n_items += len;
         end
      end
      start <= 1'b0;

      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20000) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

`default_nettype wire
